// File: rtl/dent_pkg.sv
//------------------------------------------------------------------------------
// dent_pkg
// shared constants, state types and the distance unit result bundle
//------------------------------------------------------------------------------
`default_nettype none

package dent_pkg;

    localparam int MaxCitiesDef  = 64;
    localparam int CoordWidthDef = 24;
    localparam int DistW         = 21;
    localparam int LenW          = 27;
    localparam int CityIdxW      = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_GO,
        ST_LOAD_WAIT,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_ADD,
        ST_CLOSE_RD,
        ST_JUDGE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } dent_state_t;

    typedef enum logic [1:0] {
        DU_IDLE,
        DU_SQX,
        DU_SQY,
        DU_ROOT
    } dent_du_state_t;

    typedef struct packed {
        logic             done;
        logic [DistW-1:0] dist_val;
    } dent_du_res_t;

endpackage

`default_nettype wire

// File: rtl/dent_if.sv
//------------------------------------------------------------------------------
// dent_if
// valid/ready channels for city items and tour items
//------------------------------------------------------------------------------
`default_nettype none

interface dent_in_if #(
    parameter int COORD_WIDTH = dent_pkg::CoordWidthDef
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic                          last_city;

    modport source (output valid, output coord_x, output coord_y, output last_city,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input last_city,
                    output ready);
endinterface

interface dent_out_if ();
    logic                              valid;
    logic                              ready;
    logic [dent_pkg::CityIdxW-1:0]     city_index;
    logic [dent_pkg::LenW-1:0]         tour_length;
    logic                              last_of_tour;

    modport source (output valid, output city_index, output tour_length,
                    output last_of_tour, input ready);
    modport sink   (input valid, input city_index, input tour_length,
                    input last_of_tour, output ready);
endinterface

`default_nettype wire

// File: rtl/double_ended_nearest_neighbor_tour.sv
//------------------------------------------------------------------------------
// double_ended_nearest_neighbor_tour
// loads cities, keeps a pairwise distance memory and emits the shortest
// double-ended greedy tour over all start cities
//------------------------------------------------------------------------------
// channel  dir  item                               accepted when
// cities   in   coord_x, coord_y, last_city        valid && ready
// tour     out  city_index, tour_length, last_of_tour valid && ready
//
// loading city k computes its distance to each earlier city in turn on the shared
// squarer and the square root loop of the distance unit
// a search over n cities tries every start city, one distance memory read per
// candidate, and copies the tour into the best memory for each start that
// improves the best tour; each tour item is then read, loaded and held until taken
// cities.ready is high only while idle; no clearing pass after reset
//------------------------------------------------------------------------------
`default_nettype none

module double_ended_nearest_neighbor_tour #(
    parameter int MAX_CITIES  = dent_pkg::MaxCitiesDef,
    parameter int COORD_WIDTH = dent_pkg::CoordWidthDef
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dent_in_if.sink    cities,
    dent_out_if.source tour
);

    localparam int CW   = COORD_WIDTH;
    localparam int IW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int NW   = $clog2(MAX_CITIES + 1);
    localparam int AW   = 2 * IW;
    localparam int RING = 1 << IW;
    localparam int DW   = dent_pkg::DistW;
    localparam int LW   = dent_pkg::LenW;

    dent_pkg::dent_state_t state_reg, state_next;

    logic [2*CW-1:0] city_mem [RING];
    logic [DW-1:0]   dist_mem [1 << AW];
    logic [IW-1:0]   part_mem [RING];
    logic [IW-1:0]   best_mem [RING];

    logic [NW-1:0]   count_reg, count_next;
    logic [CW-1:0]   cur_x_reg, cur_y_reg;
    logic            last_reg;
    logic [IW-1:0]   idx_reg, s_reg, head_reg, front_reg, back_reg;
    logic [NW-1:0]   len_reg;
    logic [MAX_CITIES-1:0] visited_reg;
    logic            scan_front_reg;
    logic            tag_valid_reg, tag_valid_next;
    logic [IW-1:0]   tag_j_reg;
    logic            tag_front_reg;
    logic [DW:0]     bestd_reg;
    logic [IW-1:0]   pick_reg;
    logic            pick_front_reg;
    logic [LW-1:0]   total_reg, best_len_reg;
    logic            close_zero_reg;
    logic [2*CW-1:0] city_rd_reg;
    logic [DW-1:0]   dist_rd_reg;
    logic [IW-1:0]   part_rd_reg, best_rd_reg;
    logic            out_valid_reg, out_valid_next;
    logic [dent_pkg::CityIdxW-1:0] out_idx_reg;
    logic            out_last_reg;

    logic            in_fire, out_fire, room, idx_last, s_last, take, better;
    logic            city_we, dist_we, part_we, best_we, du_start;
    logic [IW-1:0]   rd_a, rd_b, ref_city, part_wa, part_wd, part_ra;
    logic [AW-1:0]   dist_ra, dist_wa;
    logic [LW-1:0]   total_sum;
    logic [DW:0]     cand;
    logic signed [CW:0] dx, dy;
    logic [CW-1:0]   cx, cy;
    dent_pkg::dent_du_res_t du_res;

    assign in_fire  = cities.valid && cities.ready;
    assign out_fire = tour.valid && tour.ready;
    assign room     = count_reg < NW'(MAX_CITIES);
    assign idx_last = (NW'(idx_reg) + NW'(1)) == count_reg;
    assign s_last   = (NW'(s_reg) + NW'(1)) == count_reg;

    assign cities.ready     = state_reg == dent_pkg::ST_IDLE;
    assign tour.valid       = out_valid_reg;
    assign tour.city_index  = out_idx_reg;
    assign tour.tour_length = best_len_reg;
    assign tour.last_of_tour = out_last_reg;

    assign cx = city_rd_reg[2*CW-1:CW];
    assign cy = city_rd_reg[CW-1:0];
    assign dx = $signed({cur_x_reg[CW-1], cur_x_reg}) - $signed({cx[CW-1], cx});
    assign dy = $signed({cur_y_reg[CW-1], cur_y_reg}) - $signed({cy[CW-1], cy});

    dent_dist_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (du_start),
        .dx    (dx),
        .dy    (dy),
        .res   (du_res)
    );

    // distances live once per pair, at {higher index, lower index}
    assign ref_city = scan_front_reg ? front_reg : back_reg;
    assign rd_a     = (state_reg == dent_pkg::ST_CLOSE_RD) ? front_reg : ref_city;
    assign rd_b     = (state_reg == dent_pkg::ST_CLOSE_RD) ? back_reg : idx_reg;
    assign dist_ra  = (rd_a > rd_b) ? {rd_a, rd_b} : {rd_b, rd_a};
    assign dist_wa  = {count_reg[IW-1:0], idx_reg};

    assign part_ra  = head_reg + idx_reg;
    assign part_wa  = (state_reg == dent_pkg::ST_START) ? '0 :
                      pick_front_reg ? head_reg - IW'(1) : head_reg + len_reg[IW-1:0];
    assign part_wd  = (state_reg == dent_pkg::ST_START) ? s_reg : pick_reg;

    assign cand      = {1'b0, dist_rd_reg};
    assign take      = tag_valid_reg && (cand < bestd_reg);
    assign total_sum = total_reg + (close_zero_reg ? '0 : LW'(dist_rd_reg));
    assign better    = total_sum < best_len_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dent_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (room && count_reg != '0)
                        state_next = dent_pkg::ST_LOAD_RD;
                    else if (cities.last_city)
                        state_next = dent_pkg::ST_START;
                end
            end
            dent_pkg::ST_LOAD_RD:   state_next = dent_pkg::ST_LOAD_GO;
            dent_pkg::ST_LOAD_GO:   state_next = dent_pkg::ST_LOAD_WAIT;
            dent_pkg::ST_LOAD_WAIT:
            begin
                if (du_res.done)
                begin
                    if (!idx_last)
                        state_next = dent_pkg::ST_LOAD_RD;
                    else if (last_reg)
                        state_next = dent_pkg::ST_START;
                    else
                        state_next = dent_pkg::ST_IDLE;
                end
            end
            dent_pkg::ST_START:
                state_next = (count_reg == NW'(1)) ? dent_pkg::ST_CLOSE_RD : dent_pkg::ST_SCAN;
            dent_pkg::ST_SCAN:
                if (scan_front_reg && idx_last) state_next = dent_pkg::ST_DRAIN;
            dent_pkg::ST_DRAIN:     state_next = dent_pkg::ST_ADD;
            dent_pkg::ST_ADD:
                state_next = (len_reg + NW'(1) == count_reg) ? dent_pkg::ST_CLOSE_RD
                                                             : dent_pkg::ST_SCAN;
            dent_pkg::ST_CLOSE_RD:  state_next = dent_pkg::ST_JUDGE;
            dent_pkg::ST_JUDGE:
                state_next = better ? dent_pkg::ST_COPY_RD : dent_pkg::ST_NEXT;
            dent_pkg::ST_COPY_RD:   state_next = dent_pkg::ST_COPY_WR;
            dent_pkg::ST_COPY_WR:
                state_next = idx_last ? dent_pkg::ST_NEXT : dent_pkg::ST_COPY_RD;
            dent_pkg::ST_NEXT:
                state_next = s_last ? dent_pkg::ST_OUT_RD : dent_pkg::ST_START;
            dent_pkg::ST_OUT_RD:    state_next = dent_pkg::ST_OUT_LD;
            dent_pkg::ST_OUT_LD:    state_next = dent_pkg::ST_OUT_WAIT;
            dent_pkg::ST_OUT_WAIT:
            begin
                if (out_fire)
                    state_next = out_last_reg ? dent_pkg::ST_IDLE : dent_pkg::ST_OUT_RD;
            end
            default:                state_next = dent_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        city_we  = 1'b0;
        dist_we  = 1'b0;
        part_we  = 1'b0;
        best_we  = 1'b0;
        du_start = 1'b0;
        unique case (state_reg)
            dent_pkg::ST_IDLE:      city_we  = in_fire && room;
            dent_pkg::ST_LOAD_GO:   du_start = 1'b1;
            dent_pkg::ST_LOAD_WAIT: dist_we  = du_res.done;
            dent_pkg::ST_START:     part_we  = 1'b1;
            dent_pkg::ST_ADD:       part_we  = 1'b1;
            dent_pkg::ST_COPY_WR:   best_we  = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (state_reg == dent_pkg::ST_IDLE && in_fire && room && count_reg == '0)
            count_next = NW'(1);
        else if (state_reg == dent_pkg::ST_LOAD_WAIT && du_res.done && idx_last)
            count_next = count_reg + NW'(1);
        else if (state_reg == dent_pkg::ST_OUT_WAIT && out_fire && out_last_reg)
            count_next = '0;

        tag_valid_next = (state_reg == dent_pkg::ST_SCAN) && !visited_reg[idx_reg];

        out_valid_next = out_valid_reg;
        if (state_reg == dent_pkg::ST_OUT_LD)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dent_pkg::ST_IDLE;
            count_reg     <= '0;
            tag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tag_valid_reg <= tag_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (city_we)
            city_mem[count_reg[IW-1:0]] <= {cities.coord_x, cities.coord_y};
        city_rd_reg <= city_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= du_res.dist_val;
        dist_rd_reg <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (part_we)
            part_mem[part_wa] <= part_wd;
        part_rd_reg <= part_mem[part_ra];
    end

    always_ff @(posedge clk)
    begin
        if (best_we)
            best_mem[idx_reg] <= part_rd_reg;
        best_rd_reg <= best_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bestd_reg      <= cand;
            pick_reg       <= tag_j_reg;
            pick_front_reg <= tag_front_reg;
        end
        case (state_reg)
            dent_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cur_x_reg    <= cities.coord_x;
                    cur_y_reg    <= cities.coord_y;
                    last_reg     <= cities.last_city;
                    idx_reg      <= '0;
                    s_reg        <= '0;
                    best_len_reg <= {LW{1'b1}};
                end
            end
            dent_pkg::ST_LOAD_WAIT:
            begin
                if (du_res.done)
                    idx_reg <= idx_reg + IW'(1);
            end
            dent_pkg::ST_START:
            begin
                head_reg       <= '0;
                front_reg      <= s_reg;
                back_reg       <= s_reg;
                visited_reg    <= MAX_CITIES'(1) << s_reg;
                len_reg        <= NW'(1);
                total_reg      <= '0;
                idx_reg        <= '0;
                scan_front_reg <= 1'b0;
                bestd_reg      <= {(DW+1){1'b1}};
            end
            dent_pkg::ST_SCAN:
            begin
                tag_j_reg     <= idx_reg;
                tag_front_reg <= scan_front_reg;
                if (idx_last)
                begin
                    idx_reg        <= '0;
                    scan_front_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            dent_pkg::ST_ADD:
            begin
                if (pick_front_reg)
                begin
                    head_reg  <= head_reg - IW'(1);
                    front_reg <= pick_reg;
                end
                else
                begin
                    back_reg <= pick_reg;
                end
                total_reg             <= total_reg + LW'(bestd_reg[DW-1:0]);
                len_reg               <= len_reg + NW'(1);
                visited_reg[pick_reg] <= 1'b1;
                idx_reg               <= '0;
                scan_front_reg        <= 1'b0;
                bestd_reg             <= {(DW+1){1'b1}};
            end
            dent_pkg::ST_CLOSE_RD:
            begin
                close_zero_reg <= front_reg == back_reg;
            end
            dent_pkg::ST_JUDGE:
            begin
                if (better)
                    best_len_reg <= total_sum;
                idx_reg <= '0;
            end
            dent_pkg::ST_COPY_WR:
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            dent_pkg::ST_NEXT:
            begin
                s_reg   <= s_reg + IW'(1);
                idx_reg <= '0;
            end
            dent_pkg::ST_OUT_LD:
            begin
                out_idx_reg  <= dent_pkg::CityIdxW'(best_rd_reg);
                out_last_reg <= idx_last;
            end
            dent_pkg::ST_OUT_WAIT:
            begin
                if (out_fire)
                    idx_reg <= idx_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dent_dist_unit.sv
//------------------------------------------------------------------------------
// dent_dist_unit
// rounded euclidean distance over 16: one shared squarer, then a bit-pair square root
//------------------------------------------------------------------------------
`default_nettype none

module dent_dist_unit #(
    parameter int COORD_WIDTH = dent_pkg::CoordWidthDef
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [COORD_WIDTH:0]   dx,
    input  wire logic signed [COORD_WIDTH:0]   dy,
    output dent_pkg::dent_du_res_t             res
);

    localparam int CW  = COORD_WIDTH;
    localparam int SW  = (2 * CW + 2 > 28) ? 2 * CW + 2 : 28;
    localparam int NIT = SW / 2;
    localparam int ItW = $clog2(NIT + 1);
    localparam int DW  = dent_pkg::DistW;

    dent_pkg::dent_du_state_t state_reg, state_next;
    logic [CW-1:0]  ax_reg, ay_reg;
    logic [SW-1:0]  n_reg, r_reg, b_reg;
    logic [ItW-1:0] it_reg;
    logic           done_reg, done_next;

    logic [CW:0]    negx, negy;
    logic [CW-1:0]  ax, ay, op;
    logic [2*CW-1:0] prod;
    logic [SW-1:0]  trial, rnd, q;
    logic           ge, it_last;

    assign negx = -dx;
    assign negy = -dy;
    assign ax   = dx[CW] ? negx[CW-1:0] : dx[CW-1:0];
    assign ay   = dy[CW] ? negy[CW-1:0] : dy[CW-1:0];
    assign op   = (state_reg == dent_pkg::DU_SQX) ? ax_reg : ay_reg;
    assign prod = (2*CW)'(op) * (2*CW)'(op);

    assign trial   = r_reg + b_reg;
    assign ge      = n_reg >= trial;
    assign it_last = it_reg == ItW'(NIT - 1);

    // round half up then saturate
    assign rnd = r_reg + SW'(8);
    assign q   = rnd >> 4;
    assign res.done = done_reg;
    assign res.dist_val = (|q[SW-1:DW]) ? {DW{1'b1}} : q[DW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dent_pkg::DU_IDLE: if (start) state_next = dent_pkg::DU_SQX;
            dent_pkg::DU_SQX:  state_next = dent_pkg::DU_SQY;
            dent_pkg::DU_SQY:  state_next = dent_pkg::DU_ROOT;
            dent_pkg::DU_ROOT: if (it_last) state_next = dent_pkg::DU_IDLE;
            default:           state_next = dent_pkg::DU_IDLE;
        endcase
    end

    always_comb
    begin
        done_next = (state_reg == dent_pkg::DU_ROOT) && it_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dent_pkg::DU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            dent_pkg::DU_IDLE:
            begin
                if (start)
                begin
                    ax_reg <= ax;
                    ay_reg <= ay;
                end
            end
            dent_pkg::DU_SQX:
            begin
                n_reg <= SW'(prod);
            end
            dent_pkg::DU_SQY:
            begin
                n_reg  <= n_reg + SW'(prod);
                r_reg  <= '0;
                b_reg  <= SW'(1) << (SW - 2);
                it_reg <= '0;
            end
            default:
            begin
                if (ge)
                begin
                    n_reg <= n_reg - trial;
                    r_reg <= (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                b_reg  <= b_reg >> 2;
                it_reg <= it_reg + ItW'(1);
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dent_checker.sv
//------------------------------------------------------------------------------
// dent_checker
// port-level checks on the city and tour channels
//------------------------------------------------------------------------------
`default_nettype none

module dent_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          in_last,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [dent_pkg::CityIdxW-1:0] out_idx,
    input wire logic [dent_pkg::LenW-1:0]     out_len,
    input wire logic                          out_last
);

    // stalled tour item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_idx) && $stable(out_len)
                                    && $stable(out_last))
        else $error("tour item changed while stalled");

    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("city channel open while a tour item is shown");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("tour item after the final one");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("city taken right after a final city");

endmodule

bind double_ended_nearest_neighbor_tour dent_checker u_dent_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cities.valid),
    .in_ready  (cities.ready),
    .in_last   (cities.last_city),
    .out_valid (tour.valid),
    .out_ready (tour.ready),
    .out_idx   (tour.city_index),
    .out_len   (tour.tour_length),
    .out_last  (tour.last_of_tour)
);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench for double_ended_nearest_neighbor_tour
// drives jobs of cities over the city channel and checks every tour item
// against a local greedy tour search: single city, extreme coordinates,
// tied distances, too many cities, random jobs under idling and backpressure
//------------------------------------------------------------------------------
module testbench;

    typedef logic signed [dent_pkg::CoordWidthDef-1:0] coord_t;
    typedef logic [dent_pkg::CityIdxW-1:0]             city_idx_t;
    typedef logic [dent_pkg::LenW-1:0]                 len_t;

    typedef struct {
        city_idx_t city_index;
        len_t      tour_length;
        logic      last_of_tour;
    } tour_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dent_in_if  cities ();
    dent_out_if tour ();

    double_ended_nearest_neighbor_tour dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cities(cities.sink),
        .tour  (tour.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    longint     city_x [dent_pkg::MaxCitiesDef];
    longint     city_y [dent_pkg::MaxCitiesDef];
    logic [dent_pkg::DistW-1:0] pair_dist [dent_pkg::MaxCitiesDef][dent_pkg::MaxCitiesDef];
    int         loaded_cities = 0;
    tour_item_t tour_expected [$];
    int         fail_count = 0;
    int         items_sent = 0;
    int         jobs_sent = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_active = 1'b0;
    event       hold_go;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [dent_pkg::DistW-1:0] euclid(int a, int b);
        longint          dx;
        longint          dy;
        longint unsigned d;
        dx = city_x[a] - city_x[b];
        dy = city_y[a] - city_y[b];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        d = (int_sqrt(dx * dx + dy * dy) + 8) >> 4;
        if (d > 64'd2097151) d = 64'd2097151;
        return d[dent_pkg::DistW-1:0];
    endfunction

    // greedy double-ended search over all starts, queues the winning tour
    task automatic predict_tour();
        int         n;
        int         head;
        int         len;
        int         back_c;
        int         front_c;
        int         pick;
        int         best_d;
        int         total;
        int         best_len;
        bit         at_back;
        int         ring [dent_pkg::MaxCitiesDef];
        int         best_ring [dent_pkg::MaxCitiesDef];
        bit         seen [dent_pkg::MaxCitiesDef];
        tour_item_t t;
        n = loaded_cities;
        best_len = 134217727;
        for (int s = 0; s < n; s++)
        begin
            foreach (seen[j]) seen[j] = 1'b0;
            head = 0;
            len = 1;
            ring[0] = s;
            seen[s] = 1'b1;
            while (len < n)
            begin
                back_c = ring[(head + len - 1) & 63];
                front_c = ring[head];
                best_d = 32'h7fffffff;
                pick = 0;
                at_back = 1'b1;
                for (int j = 0; j < n; j++)
                    if (!seen[j] && pair_dist[back_c][j] < best_d)
                    begin
                        best_d = pair_dist[back_c][j];
                        pick = j;
                        at_back = 1'b1;
                    end
                for (int j = 0; j < n; j++)
                    if (!seen[j] && pair_dist[front_c][j] < best_d)
                    begin
                        best_d = pair_dist[front_c][j];
                        pick = j;
                        at_back = 1'b0;
                    end
                if (at_back)
                    ring[(head + len) & 63] = pick;
                else
                begin
                    head = (head - 1) & 63;
                    ring[head] = pick;
                end
                len++;
                seen[pick] = 1'b1;
            end
            total = 0;
            for (int k = 0; k + 1 < len; k++)
                total += pair_dist[ring[(head + k) & 63]][ring[(head + k + 1) & 63]];
            total += pair_dist[ring[head]][ring[(head + len - 1) & 63]];
            if (total < best_len)
            begin
                best_len = total;
                for (int k = 0; k < len; k++)
                    best_ring[k] = ring[(head + k) & 63];
            end
        end
        for (int k = 0; k < n; k++)
        begin
            t.city_index = city_idx_t'(best_ring[k]);
            t.tour_length = len_t'(best_len);
            t.last_of_tour = (k + 1 == n);
            tour_expected = {tour_expected, t};
        end
        loaded_cities = 0;
    endtask

    task automatic load_city(coord_t x, coord_t y, logic last);
        int c;
        if (loaded_cities < dent_pkg::MaxCitiesDef)
        begin
            c = loaded_cities;
            city_x[c] = x;
            city_y[c] = y;
            pair_dist[c][c] = '0;
            for (int j = 0; j < c; j++)
            begin
                pair_dist[c][j] = euclid(c, j);
                pair_dist[j][c] = pair_dist[c][j];
            end
            loaded_cities++;
        end
        if (last)
        begin
            predict_tour();
            jobs_sent++;
        end
    endtask

    task automatic send_city(coord_t x, coord_t y, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            cities.valid <= 1'b0;
            @(posedge clk);
        end
        cities.valid <= 1'b1;
        cities.coord_x <= x;
        cities.coord_y <= y;
        cities.last_city <= last;
        do
            @(posedge clk);
        while (!cities.ready);
        items_sent++;
        load_city(x, y, last);
    endtask

    task automatic pause_input();
        cities.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_tour();
        pause_input();
        while (tour_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_job(int max_n);
        int  n;
        bit  wide;
        n = $urandom_range(max_n, 1);
        wide = 1'($urandom_range(1));
        for (int k = 0; k < n; k++)
            if (wide)
                send_city(coord_t'($urandom), coord_t'($urandom), k == n - 1);
            else
                send_city(coord_t'($urandom_range(128) - 64),
                          coord_t'($urandom_range(128) - 64), k == n - 1);
    endtask

    // long output stall, counted here
    always
    begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin
        tour_item_t e;
        if (tour.valid && tour.ready)
        begin
            if (tour_expected.size() == 0)
            begin
                $error("unexpected tour item city_index %0d", tour.city_index);
                fail_count++;
            end
            else
            begin
                e = tour_expected.pop_front();
                if (tour.city_index !== e.city_index)
                begin
                    $error("city_index expected %0d actual %0d", e.city_index, tour.city_index);
                    fail_count++;
                end
                if (tour.tour_length !== e.tour_length)
                begin
                    $error("tour_length expected %0d actual %0d",
                           e.tour_length, tour.tour_length);
                    fail_count++;
                end
                if (tour.last_of_tour !== e.last_of_tour)
                begin
                    $error("last_of_tour expected %0d actual %0d",
                           e.last_of_tour, tour.last_of_tour);
                    fail_count++;
                end
            end
        end
        if (!rst_n)
            tour.ready <= 1'b0;
        else if (hold_active)
            tour.ready <= 1'b0;
        else
            tour.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic test_single_city();
        send_city(24'sh7fffff, 24'sh800000, 1'b1);
        send_city(24'sh000000, 24'sh000000, 1'b1);
        drain_tour();
    endtask

    task automatic test_extreme_pair();
        send_city(24'sh800000, 24'sh800000, 1'b0);
        send_city(24'sh7fffff, 24'sh7fffff, 1'b1);
        send_city(24'sh800000, 24'sh7fffff, 1'b0);
        send_city(24'sh7fffff, 24'sh800000, 1'b0);
        send_city(24'shffffff, 24'sh000001, 1'b1);
        drain_tour();
    endtask

    task automatic test_ties();
        // coincident cities, then a square where every side ties
        send_city(24'sd16, 24'sd16, 1'b0);
        send_city(24'sd16, 24'sd16, 1'b0);
        send_city(24'sd16, 24'sd16, 1'b1);
        send_city(24'sd0, 24'sd0, 1'b0);
        send_city(24'sd160, 24'sd0, 1'b0);
        send_city(24'sd160, 24'sd160, 1'b0);
        send_city(24'sd0, 24'sd160, 1'b0);
        send_city(24'sd80, 24'sd8, 1'b1);
        // half-unit rounding
        send_city(24'sd0, 24'sd0, 1'b0);
        send_city(24'sd8, 24'sd0, 1'b0);
        send_city(24'sd7, 24'sd0, 1'b1);
        drain_tour();
    endtask

    task automatic test_too_many_cities();
        for (int k = 0; k < dent_pkg::MaxCitiesDef + 2; k++)
            send_city(coord_t'($urandom_range(4000) - 2000),
                      coord_t'($urandom_range(4000) - 2000),
                      k == dent_pkg::MaxCitiesDef + 1);
        drain_tour();
    endtask

    task automatic test_random_phases();
        int pct_idle [4] = '{0, 55, 0, 31};
        int pct_stall [4] = '{0, 0, 55, 31};
        int base;
        base = items_sent;
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = pct_idle[p];
            stall_pct = pct_stall[p];
            while (items_sent < base + 10 * (p + 1))
                send_random_job(6);
            drain_tour();
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        -> hold_go;
        repeat (4)
            send_random_job(5);
        drain_tour();
    endtask

    initial
    begin
        cities.valid = 1'b0;
        cities.coord_x = '0;
        cities.coord_y = '0;
        cities.last_city = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_city();
        test_extreme_pair();
        test_ties();
        test_too_many_cities();
        test_random_phases();
        test_backpressure();
        repeat (100) @(posedge clk);
        $display("covered %0d city items in %0d jobs: single city, extremes, ties,",
                 items_sent, jobs_sent);
        $display("overflow past the city limit, idling phases and long output stall");
        if (fail_count == 0 && tour_expected.size() == 0)
            $display("PASS double_ended_nearest_neighbor_tour");
        else
            $display("FAIL double_ended_nearest_neighbor_tour");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("FAIL double_ended_nearest_neighbor_tour");
        $finish;
    end

endmodule
